@@ design/pre_pkg.sv @@
// shared types and constants for the photometric reprojection error unit
// no dependencies
package pre_pkg;

    // widest store address, for frames of up to 4096 by 4096
    localparam int ADDR_W_MAX = 24;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_DEPTH_SCALE = 3'd4,
        CFG_POSE_X      = 3'd5,
        CFG_POSE_Y      = 3'd6,
        CFG_POSE_Z      = 3'd7
    } cfg_index_t;

    // camera and pose settings seen by the front end
    typedef struct packed {
        logic [30:0] focal_x;
        logic [30:0] focal_y;
        logic [30:0] center_x;
        logic [30:0] center_y;
        logic [31:0] depth_scale;
        logic [63:0] pose_x;
        logic [63:0] pose_y;
        logic [63:0] pose_z;
    } cfg_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic                  is_load;
        logic                  hit;
        logic                  fend;
        logic [7:0]            intensity;
        logic [ADDR_W_MAX-1:0] addr;
    } q_entry_t;

endpackage

@@ design/pre_div.sv @@
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on nothing
module pre_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg;
    logic [39:0] rem_reg;
    logic [39:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [40:0] shifted;
    logic [40:0] trial;

    // one restoring step
    always_comb begin
        shifted = {rem_reg, q_reg[63]};
        trial   = shifted - {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[40]) begin
                rem_reg <= trial[39:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shifted[39:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ design/pre_front.sv @@
// front end: accepts items, projects evaluated pixels, pushes classified entries
// depends on pre_pkg and pre_div
module pre_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pre_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_req_type,
    input  logic [9:0]        in_col,
    input  logic [8:0]        in_row,
    input  logic [7:0]        in_intensity,
    input  logic [15:0]       in_depth_raw,
    input  logic              in_frame_end,
    output logic              q_push,
    output pre_pkg::q_entry_t q_entry,
    input  logic              q_full
);

    localparam int UW = (FRAME_WIDTH > 2) ? $clog2(FRAME_WIDTH) : 1;
    localparam int VW = (FRAME_HEIGHT > 2) ? $clog2(FRAME_HEIGHT) : 1;
    localparam logic [63:0] W_LIM = 64'(FRAME_WIDTH) << 32;
    localparam logic [63:0] H_LIM = 64'(FRAME_HEIGHT) << 32;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ZMUL   = 9'b000000010,
        ST_BP_MUL = 9'b000000100,
        ST_BP_DIV = 9'b000001000,
        ST_POSE   = 9'b000010000,
        ST_PJ_DIV = 9'b000100000,
        ST_PJ_MUL = 9'b001000000,
        ST_PJ_ADD = 9'b010000000,
        ST_PUSH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic                     axis_reg;
    logic [9:0]               col_reg;
    logic [8:0]               row_reg;
    logic [7:0]               int_reg;
    logic [15:0]              draw_reg;
    logic                     fend_reg;
    logic [31:0]              z_reg;
    logic signed [63:0]       prod_reg;
    logic signed [31:0]       bp_x_reg, bp_y_reg;
    logic signed [51:0]       acc_reg;
    logic [1:0]               prow_reg, pk_reg;
    logic signed [37:0]       pt_x_reg, pt_y_reg, pt_z_reg;
    logic                     neg_reg;
    logic                     started_reg;
    logic signed [32:0]       r_reg;
    logic                     hit_x_reg;
    logic [UW-1:0]            uc_reg;
    pre_pkg::q_entry_t        ent_reg;

    logic                     accept;
    pre_pkg::q_entry_t        imm_entry;
    logic                     imm_push;

    logic [47:0]              zprod;
    logic [9:0]               pix;
    logic [30:0]              ctr;
    logic [30:0]              foc;
    logic signed [32:0]       dval;
    logic signed [65:0]       bpm;

    logic [63:0]              pose_word;
    logic signed [15:0]       term;
    logic signed [32:0]       opnd;
    logic signed [48:0]       pmul;
    logic signed [51:0]       psum;
    logic signed [51:0]       pround;
    logic signed [37:0]       ptv;

    logic signed [37:0]       num;
    logic signed [53:0]       num_sh;
    logic                     div_start;
    logic [63:0]              div_dividend;
    logic [39:0]              div_divisor;
    logic                     div_done;
    logic [63:0]              div_q;
    logic signed [31:0]       bp_res;
    logic signed [32:0]       r_res;

    logic signed [64:0]       pjm;
    logic signed [63:0]       u1;
    logic                     in_bounds;
    logic [VW-1:0]            vc;

    assign in_ready = (state_reg == ST_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    // entry for items finished at acceptance: loads and zero-depth pixels
    always_comb begin
        imm_entry.is_load   = !in_req_type;
        imm_entry.hit       = !in_req_type && (32'(in_col) < 32'(FRAME_WIDTH))
                              && (32'(in_row) < 32'(FRAME_HEIGHT));
        imm_entry.fend      = in_req_type && in_frame_end;
        imm_entry.intensity = in_intensity;
        imm_entry.addr      = pre_pkg::ADDR_W_MAX'(32'(in_row) * 32'(FRAME_WIDTH)
                                                   + 32'(in_col));
        imm_push            = accept && (!in_req_type || (in_depth_raw == 16'd0));
    end

    assign q_push  = imm_push || ((state_reg == ST_PUSH) && !q_full);
    assign q_entry = (state_reg == ST_IDLE) ? imm_entry : ent_reg;

    // depth and back-projection operands
    always_comb begin
        zprod = 48'(draw_reg) * 48'(cfg.depth_scale);
        pix   = axis_reg ? {1'b0, row_reg} : col_reg;
        ctr   = axis_reg ? cfg.center_y : cfg.center_x;
        foc   = axis_reg ? cfg.focal_y : cfg.focal_x;
        dval  = $signed({7'b0, pix, 16'b0}) - $signed({2'b0, ctr});
        bpm   = dval * $signed({1'b0, z_reg});
    end

    // pose multiply-accumulate, one term a cycle
    always_comb begin
        case (prow_reg)
            2'd0:    pose_word = cfg.pose_x;
            2'd1:    pose_word = cfg.pose_y;
            default: pose_word = cfg.pose_z;
        endcase
        term = $signed(pose_word[16*pk_reg +: 16]);
        case (pk_reg)
            2'd0:    opnd = 33'(bp_x_reg);
            2'd1:    opnd = 33'(bp_y_reg);
            2'd2:    opnd = $signed({1'b0, z_reg});
            default: opnd = 33'sd4194304;
        endcase
        pmul   = term * opnd;
        psum   = ((pk_reg == 2'd0) ? 52'sd0 : acc_reg) + 52'(pmul);
        pround = psum + (psum[51] ? 52'sd16383 : 52'sd0);
        ptv    = 38'(pround >>> 14);
    end

    // divider operands and clamped quotients
    always_comb begin
        num          = axis_reg ? pt_y_reg : pt_x_reg;
        num_sh       = {num, 16'b0};
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        if (state_reg == ST_BP_DIV) begin
            div_start    = !started_reg;
            div_dividend = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
            div_divisor  = (foc == 31'd0) ? 40'd1 : {9'b0, foc};
        end else if (state_reg == ST_PJ_DIV) begin
            div_start    = !started_reg && (pt_z_reg > 38'sd0);
            div_dividend = num_sh[53] ? 64'(-num_sh) : 64'(num_sh);
            div_divisor  = {2'b0, pt_z_reg};
        end
        if (neg_reg) begin
            bp_res = (div_q >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
            r_res  = (div_q >= 64'h8000_0000) ? -33'sh0_8000_0000
                                              : -$signed({1'b0, div_q[31:0]});
        end else begin
            bp_res = (div_q >= 64'h8000_0000) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
            r_res  = (div_q >= 64'h8000_0000) ? 33'sh0_8000_0000
                                              : $signed({1'b0, div_q[31:0]});
        end
    end

    pre_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // projection and frame bounds
    always_comb begin
        pjm       = $signed({1'b0, foc}) * r_reg;
        u1        = prod_reg + $signed({17'b0, ctr, 16'b0});
        in_bounds = !u1[63] && (u1 != 64'sd0)
                    && (64'(u1) < (axis_reg ? H_LIM : W_LIM));
        vc        = u1[32 +: VW];
    end

    // sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && in_req_type && (in_depth_raw != 16'd0)) begin
                state_next = ST_ZMUL;
            end
            ST_ZMUL:   state_next = ST_BP_MUL;
            ST_BP_MUL: state_next = ST_BP_DIV;
            ST_BP_DIV: if (started_reg && div_done) begin
                state_next = axis_reg ? ST_POSE : ST_BP_MUL;
            end
            ST_POSE:   if ((pk_reg == 2'd3) && (prow_reg == 2'd2)) begin
                state_next = ST_PJ_DIV;
            end
            ST_PJ_DIV: if (pt_z_reg <= 38'sd0) begin
                state_next = ST_PUSH;
            end else if (started_reg && div_done) begin
                state_next = ST_PJ_MUL;
            end
            ST_PJ_MUL: state_next = ST_PJ_ADD;
            ST_PJ_ADD: state_next = axis_reg ? ST_PUSH : ST_PJ_DIV;
            ST_PUSH:   if (!q_full) begin
                state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (div_start) begin
                started_reg <= 1'b1;
            end else if (div_done) begin
                started_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (div_start) begin
            neg_reg <= (state_reg == ST_BP_DIV) ? prod_reg[63] : num_sh[53];
        end
        case (state_reg)
            ST_IDLE: begin
                col_reg  <= in_col;
                row_reg  <= in_row;
                int_reg  <= in_intensity;
                draw_reg <= in_depth_raw;
                fend_reg <= in_frame_end;
                axis_reg <= 1'b0;
            end
            ST_ZMUL: begin
                z_reg <= zprod[47:16];
            end
            ST_BP_MUL: begin
                prod_reg <= bpm[63:0];
            end
            ST_BP_DIV: begin
                if (started_reg && div_done) begin
                    if (axis_reg) begin
                        bp_y_reg <= bp_res;
                    end else begin
                        bp_x_reg <= bp_res;
                    end
                    axis_reg <= !axis_reg;
                    prow_reg <= 2'd0;
                    pk_reg   <= 2'd0;
                end
            end
            ST_POSE: begin
                acc_reg <= psum;
                pk_reg  <= pk_reg + 2'd1;
                if (pk_reg == 2'd3) begin
                    prow_reg <= prow_reg + 2'd1;
                    case (prow_reg)
                        2'd0:    pt_x_reg <= ptv;
                        2'd1:    pt_y_reg <= ptv;
                        default: pt_z_reg <= ptv;
                    endcase
                end
            end
            ST_PJ_DIV: begin
                if (pt_z_reg <= 38'sd0) begin
                    ent_reg.is_load   <= 1'b0;
                    ent_reg.hit       <= 1'b0;
                    ent_reg.fend      <= fend_reg;
                    ent_reg.intensity <= int_reg;
                    ent_reg.addr      <= '0;
                end else if (started_reg && div_done) begin
                    r_reg <= r_res;
                end
            end
            ST_PJ_MUL: begin
                prod_reg <= pjm[63:0];
            end
            ST_PJ_ADD: begin
                if (!axis_reg) begin
                    hit_x_reg <= in_bounds;
                    uc_reg    <= u1[32 +: UW];
                    axis_reg  <= 1'b1;
                end else begin
                    ent_reg.is_load   <= 1'b0;
                    ent_reg.hit       <= hit_x_reg && in_bounds;
                    ent_reg.fend      <= fend_reg;
                    ent_reg.intensity <= int_reg;
                    ent_reg.addr      <= pre_pkg::ADDR_W_MAX'(32'(vc) * 32'(FRAME_WIDTH)
                                                           + 32'(uc_reg));
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/pre_queue.sv @@
// four-entry queue between front and back end
// depends on pre_pkg
module pre_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pre_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output pre_pkg::q_entry_t head,
    output logic              empty
);

    pre_pkg::q_entry_t slot_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    assign full  = (count_reg == 3'd4);
    assign empty = (count_reg == 3'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push) - 3'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/pre_back.sv @@
// back end: frame store, running sum and result register
// depends on pre_pkg
module pre_back #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pre_pkg::q_entry_t head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [27:0]       out_sum
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]          mem [DEPTH];
    logic [7:0]          rd_reg;
    logic                s2_valid_reg;
    logic                s2_hit_reg;
    logic                s2_fend_reg;
    logic [7:0]          s2_int_reg;
    logic signed [27:0]  sum_reg, sum_next;
    logic                out_valid_reg;
    logic [27:0]         out_sum_reg;

    logic signed [8:0]   diff;
    logic signed [28:0]  wide;

    // take an entry only when its result slot is sure to be free
    assign pop = !empty && (!out_valid_reg || out_ready) && !(s2_valid_reg && s2_fend_reg);

    // frame store: write on in-frame loads, registered read for evaluations
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (head.is_load && head.hit) begin
                mem[head.addr[AW-1:0]] <= head.intensity;
            end
            rd_reg <= mem[head.addr[AW-1:0]];
        end
    end

    // saturating accumulate
    always_comb begin
        diff = $signed({1'b0, rd_reg}) - $signed({1'b0, s2_int_reg});
        wide = 29'(sum_reg) + 29'(diff);
        if (!s2_hit_reg) begin
            sum_next = sum_reg;
        end else if (wide > 29'sd134217727) begin
            sum_next = 28'sd134217727;
        end else if (wide < -29'sd134217728) begin
            sum_next = -28'sd134217728;
        end else begin
            sum_next = 28'(wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= pop && !head.is_load;
            if (s2_valid_reg && s2_fend_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (s2_valid_reg) begin
                if (s2_fend_reg) begin
                    sum_reg <= '0;
                end else begin
                    sum_reg <= sum_next;
                end
            end
        end
    end

    // second stage payload and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            s2_hit_reg  <= head.hit;
            s2_fend_reg <= head.fend;
            s2_int_reg  <= head.intensity;
        end
        if (s2_valid_reg && s2_fend_reg) begin
            out_sum_reg <= sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

@@ design/photometric_reprojection_error_unit.sv @@
// Photometric reprojection error unit. Input channel s_*: with tuser low an item
// loads one reference pixel (col, row, intensity) into the frame store; with tuser
// high it evaluates a first-image pixel with its raw depth, and tlast marks the
// frame's last evaluated pixel. Output channel m_*: one transaction per frame
// carrying the signed 28-bit error sum, after which the sum restarts from zero.
// A load or a zero-depth pixel is finished on acceptance. A pixel with depth holds
// the front end while up to four divisions run on one shared bit-serial divider,
// next to twelve pose multiply-accumulate steps.
// A four-entry queue feeds the back end, which reads the store as an entry leaves
// the queue and accumulates in the next cycle; a frame's result is valid from then on.
// The configuration port writes one register per cycle with cfg_wr_en high.
// Reset (synchronous, active low) restores the register defaults, clears the sum
// and empties the queue; the frame store holds no defined data until loaded.
// While m_tready stays low the held result stops the back end from taking
// entries; the queue then fills and s_tready drops.
// depends on pre_pkg, pre_front, pre_queue, pre_back
module photometric_reprojection_error_unit #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // col, row, intensity, depth_raw, zero pad
    input  logic        s_tuser,  // req_type
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // error_sum, zero pad
);

    pre_pkg::cfg_t     cfg_reg;
    pre_pkg::q_entry_t push_entry, head;
    logic              push, full, pop, empty;
    logic [27:0]       sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x     <= 31'd34406400;
            cfg_reg.focal_y     <= 31'd34406400;
            cfg_reg.center_x    <= 31'd20938752;
            cfg_reg.center_y    <= 31'd15695872;
            cfg_reg.depth_scale <= 32'd858993;
            cfg_reg.pose_x      <= 64'd16384;
            cfg_reg.pose_y      <= 64'd1073741824;
            cfg_reg.pose_z      <= 64'd70368744177664;
        end else if (cfg_wr_en) begin
            case (pre_pkg::cfg_index_t'(cfg_addr))
                pre_pkg::CFG_FOCAL_X:     cfg_reg.focal_x     <= cfg_wr_data[30:0];
                pre_pkg::CFG_FOCAL_Y:     cfg_reg.focal_y     <= cfg_wr_data[30:0];
                pre_pkg::CFG_CENTER_X:    cfg_reg.center_x    <= cfg_wr_data[30:0];
                pre_pkg::CFG_CENTER_Y:    cfg_reg.center_y    <= cfg_wr_data[30:0];
                pre_pkg::CFG_DEPTH_SCALE: cfg_reg.depth_scale <= cfg_wr_data[31:0];
                pre_pkg::CFG_POSE_X:      cfg_reg.pose_x      <= cfg_wr_data;
                pre_pkg::CFG_POSE_Y:      cfg_reg.pose_y      <= cfg_wr_data;
                pre_pkg::CFG_POSE_Z:      cfg_reg.pose_z      <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    pre_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_req_type  (s_tuser),
        .in_col       (s_tdata[9:0]),
        .in_row       (s_tdata[18:10]),
        .in_intensity (s_tdata[26:19]),
        .in_depth_raw (s_tdata[42:27]),
        .in_frame_end (s_tlast),
        .q_push       (push),
        .q_entry      (push_entry),
        .q_full       (full)
    );

    pre_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    pre_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sum   (sum)
    );

    assign m_tdata = {4'b0, sum};

endmodule

@@ design/pre_checker.sv @@
// port-level checks for the photometric reprojection error unit
// depends on photometric_reprojection_error_unit, attached by bind
module pre_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a held result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // pad bits above the sum stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:28] == 4'b0))
        else $error("nonzero pad in result");

endmodule

bind photometric_reprojection_error_unit pre_checker u_pre_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_photometric_reprojection_error_unit.sv @@
// testbench for the photometric reprojection error unit: reference loads, pixel
// evaluation, per-frame error sums checked against a built-in predictor
// depends on pre_pkg and photometric_reprojection_error_unit
module tb_photometric_reprojection_error_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW = 640;
    localparam int FH = 480;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef logic signed [127:0] wide_t;

    // one input transaction
    typedef struct {
        bit        evaluate;
        bit [9:0]  col;
        bit [8:0]  row;
        bit [7:0]  intensity;
        bit [15:0] depth_raw;
        bit        frame_end;
    } pixel_t;

    // frame store, camera settings and running sum, with the expected sums
    class error_scoreboard;
        bit [7:0]  frame_store [int];
        bit [30:0] focal_x, focal_y, center_x, center_y;
        bit [31:0] depth_scale;
        bit [63:0] pose_x, pose_y, pose_z;
        wide_t     running_sum;
        bit [27:0] expected_sums [$];
        int        mismatches;

        function void reset_state();
            focal_x = 31'd34406400;
            focal_y = 31'd34406400;
            center_x = 31'd20938752;
            center_y = 31'd15695872;
            depth_scale = 32'd858993;
            pose_x = 64'd16384;
            pose_y = 64'd1073741824;
            pose_z = 64'd70368744177664;
            running_sum = 0;
            mismatches = 0;
        endfunction

        function void set_register(pre_pkg::cfg_index_t idx, bit [63:0] value);
            case (idx)
                pre_pkg::CFG_FOCAL_X: focal_x = value[30:0];
                pre_pkg::CFG_FOCAL_Y: focal_y = value[30:0];
                pre_pkg::CFG_CENTER_X: center_x = value[30:0];
                pre_pkg::CFG_CENTER_Y: center_y = value[30:0];
                pre_pkg::CFG_DEPTH_SCALE: depth_scale = value[31:0];
                pre_pkg::CFG_POSE_X: pose_x = value;
                pre_pkg::CFG_POSE_Y: pose_y = value;
                pre_pkg::CFG_POSE_Z: pose_z = value;
                default: ;
            endcase
        endfunction

        function wide_t clamp(wide_t v, wide_t lo, wide_t hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function wide_t pose_term(bit [63:0] prow, int pos);
            logic signed [15:0] t;
            wide_t w;
            t = prow[16*pos +: 16];
            w = t;
            return w;
        endfunction

        function wide_t back_project(wide_t pix, bit [30:0] center, bit [30:0] focal,
                                     wide_t z);
            wide_t d, f, c;
            c = {97'd0, center};
            d = pix * 65536 - c;
            f = (focal == 0) ? wide_t'(1) : {97'd0, focal};
            return clamp(d * z / f, -wide_t'(64'sd2147483648), wide_t'(64'sd2147483647));
        endfunction

        function wide_t rotate(bit [63:0] prow, wide_t x, wide_t y, wide_t z);
            wide_t acc;
            acc = pose_term(prow, 0) * x + pose_term(prow, 1) * y
                + pose_term(prow, 2) * z + pose_term(prow, 3) * 4194304;
            return acc / 16384;
        endfunction

        function wide_t reproject(wide_t num, wide_t den, bit [30:0] focal,
                                  bit [30:0] center);
            wide_t r, f, c;
            r = clamp(num * 65536 / den, -wide_t'(64'sd2147483648),
                      wide_t'(64'sd2147483648));
            f = {97'd0, focal};
            c = {97'd0, center};
            return f * r + c * 65536;
        endfunction

        // store address that an evaluated pixel reads, or 0 if it adds nothing
        function bit target_of(pixel_t p, output int addr);
            bit [63:0] zr;
            wide_t z, x, y, xt, yt, zt, u, v;
            addr = 0;
            if (p.depth_raw == 0) return 0;
            zr = ({48'd0, p.depth_raw} * {32'd0, depth_scale}) >> 16;
            z = {64'd0, zr};
            x = back_project({118'd0, p.col}, center_x, focal_x, z);
            y = back_project({119'd0, p.row}, center_y, focal_y, z);
            xt = rotate(pose_x, x, y, z);
            yt = rotate(pose_y, x, y, z);
            zt = rotate(pose_z, x, y, z);
            if (zt <= 0) return 0;
            u = reproject(xt, zt, focal_x, center_x);
            v = reproject(yt, zt, focal_y, center_y);
            if (!(u > 0 && u < (wide_t'(FW) << 32) && v > 0 && v < (wide_t'(FH) << 32)))
                return 0;
            addr = int'(v >>> 32) * FW + int'(u >>> 32);
            return 1;
        endfunction

        // an input transaction was accepted
        function void note_pixel(pixel_t p);
            int addr;
            if (!p.evaluate) begin
                if (p.col < FW && p.row < FH) frame_store[p.row * FW + p.col] = p.intensity;
                return;
            end
            if (target_of(p, addr))
                running_sum = clamp(running_sum + frame_store[addr] - p.intensity,
                                    -wide_t'(134217728), wide_t'(134217727));
            if (p.frame_end) begin
                expected_sums.push_back(running_sum[27:0]);
                running_sum = 0;
            end
        endfunction

        // an output transaction was accepted
        function void check_sum(bit [27:0] actual);
            bit [27:0] want;
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected error sum %0d", $time, $signed(actual));
                mismatches++;
                return;
            end
            want = expected_sums.pop_front();
            if (want !== actual) begin
                $display("%0t: error_sum expected %0d actual %0d", $time,
                         $signed(want), $signed(actual));
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;  // col, row, intensity, depth_raw, zero pad
    logic        s_tuser;  // req_type
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;  // error_sum, zero pad

    error_scoreboard sb;
    bit no_idle;
    int idle_cycles = 0;

    photometric_reprojection_error_unit u_top (.*);

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result receiver with random stalls
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : int'($urandom_range(0, 5));
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_sum(m_tdata[27:0]);
        end
    end

    task automatic write_register(pre_pkg::cfg_index_t idx, bit [63:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_register(idx, value);
    endtask

    // drive one transaction, called at a falling edge
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 5));
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = p.evaluate;
        s_tlast = p.frame_end;
        s_tdata = {5'd0, p.depth_raw, p.intensity, p.row, p.col};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(p);
        @(negedge aclk);
    endtask

    task automatic send_load(int col, int row, bit [7:0] intensity, bit fend);
        pixel_t p;
        p.evaluate = 1'b0;
        p.col = 10'(col);
        p.row = 9'(row);
        p.intensity = intensity;
        p.depth_raw = 16'($urandom);
        p.frame_end = fend;
        send_pixel(p);
    endtask

    // evaluate a pixel, loading its target entry first if never written
    task automatic send_eval(pixel_t p);
        int addr;
        p.evaluate = 1'b1;
        if (sb.target_of(p, addr) && !sb.frame_store.exists(addr))
            send_load(addr % FW, addr / FW, 8'($urandom), 1'($urandom_range(0, 1)));
        send_pixel(p);
    endtask

    function automatic pixel_t random_pixel(bit fend);
        pixel_t p;
        p.evaluate = 1'b1;
        p.col = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(0, FW - 1));
        p.row = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(0, FH - 1));
        p.intensity = 8'($urandom);
        case ($urandom_range(0, 7))
            0: p.depth_raw = 16'd0;
            1: p.depth_raw = 16'($urandom);
            default: p.depth_raw = 16'($urandom_range(2000, 20000));
        endcase
        p.frame_end = fend;
        return p;
    endfunction

    // frames of random pixels mixed with reference loads
    task automatic random_frames(int items);
        int left, len;
        left = items;
        while (left > 0) begin
            len = int'($urandom_range(1, 16));
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 4) == 0)
                    send_load(int'($urandom_range(0, 1023)), int'($urandom_range(0, 511)),
                              8'($urandom), 1'($urandom_range(0, 1)));
                send_eval(random_pixel(i == len - 1));
            end
            left -= len;
        end
    endtask

    // hold off until all sums are back and the pipeline has drained
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.expected_sums.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic bit [63:0] near_identity(int axis);
        bit [63:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = 16'((k == axis ? 16384 : 0)
                                + int'($urandom_range(0, 600)) - 300);
        r[63:48] = 16'(int'($urandom_range(0, 200)) - 100);
        return r;
    endfunction

    task automatic directed_part();
        pixel_t p;
        send_load(0, 0, 8'd0, 1'b0);
        send_load(FW - 1, FH - 1, 8'd255, 1'b1);
        send_load(1023, 511, 8'd77, 1'b0);
        send_load(FW, 3, 8'd12, 1'b1);
        send_load(5, FH, 8'd12, 1'b0);
        p = random_pixel(1'b0);
        p.depth_raw = 0;
        send_eval(p);
        p.col = 0; p.row = 0; p.depth_raw = 16'hffff; p.intensity = 8'd255;
        send_eval(p);
        p.col = FW - 1; p.row = FH - 1; p.depth_raw = 16'd1; p.intensity = 8'd0;
        send_eval(p);
        p.col = 1023; p.row = 511; p.depth_raw = 16'd5000;
        send_eval(p);
        p.col = 320; p.row = 240; p.depth_raw = 16'd5000; p.intensity = 8'd0;
        send_eval(p);
        p.col = 100; p.row = 50; p.intensity = 8'd255;
        send_eval(p);
        p.col = 1; p.row = 1; p.depth_raw = 16'h8000; p.frame_end = 1'b1;
        send_eval(p);
        // frame of only one zero-depth pixel
        p.depth_raw = 0;
        send_eval(p);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        no_idle = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = pre_pkg::CFG_FOCAL_X;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings
        directed_part();
        random_frames(65);
        wait_idle();

        // perturbed camera and pose, every register written
        write_register(pre_pkg::CFG_FOCAL_X, 64'(34406400 + $urandom_range(0, 3000000)));
        write_register(pre_pkg::CFG_FOCAL_Y, 64'(34406400 - $urandom_range(0, 3000000)));
        write_register(pre_pkg::CFG_CENTER_X, 64'($urandom_range(15000000, 25000000)));
        write_register(pre_pkg::CFG_CENTER_Y, 64'($urandom_range(12000000, 18000000)));
        write_register(pre_pkg::CFG_DEPTH_SCALE, 64'($urandom_range(400000, 1200000)));
        write_register(pre_pkg::CFG_POSE_X, near_identity(0));
        write_register(pre_pkg::CFG_POSE_Y, near_identity(1));
        write_register(pre_pkg::CFG_POSE_Z, near_identity(2));
        random_frames(65);
        wait_idle();

        // extremes: widest focal, zero center, smallest scale, point behind camera
        write_register(pre_pkg::CFG_FOCAL_X, 64'h7fffffff);
        write_register(pre_pkg::CFG_FOCAL_Y, 64'h7fffffff);
        write_register(pre_pkg::CFG_CENTER_X, 64'd0);
        write_register(pre_pkg::CFG_CENTER_Y, 64'd0);
        write_register(pre_pkg::CFG_DEPTH_SCALE, 64'd1);
        write_register(pre_pkg::CFG_POSE_Z, 64'h8000_4000_0000_0000);
        random_frames(30);
        wait_idle();

        // zero focal, largest scale, arbitrary pose bits
        write_register(pre_pkg::CFG_FOCAL_X, 64'd0);
        write_register(pre_pkg::CFG_FOCAL_Y, 64'd0);
        write_register(pre_pkg::CFG_CENTER_X, 64'h7fffffff);
        write_register(pre_pkg::CFG_CENTER_Y, 64'h7fffffff);
        write_register(pre_pkg::CFG_DEPTH_SCALE, 64'hffffffff);
        write_register(pre_pkg::CFG_POSE_X, {$urandom, $urandom});
        write_register(pre_pkg::CFG_POSE_Y, 64'hffff_ffff_ffff_ffff);
        write_register(pre_pkg::CFG_POSE_Z, {$urandom, $urandom});
        random_frames(30);
        wait_idle();

        // back to the reset camera, first without gaps then with them
        write_register(pre_pkg::CFG_FOCAL_X, 64'd34406400);
        write_register(pre_pkg::CFG_FOCAL_Y, 64'd34406400);
        write_register(pre_pkg::CFG_CENTER_X, 64'd20938752);
        write_register(pre_pkg::CFG_CENTER_Y, 64'd15695872);
        write_register(pre_pkg::CFG_DEPTH_SCALE, 64'd858993);
        write_register(pre_pkg::CFG_POSE_X, near_identity(0));
        write_register(pre_pkg::CFG_POSE_Y, near_identity(1));
        write_register(pre_pkg::CFG_POSE_Z, 64'd70368744177664);
        no_idle = 1'b1;
        random_frames(50);
        no_idle = 1'b0;
        random_frames(60);
        wait_idle();

        if (sb.mismatches == 0 && sb.expected_sums.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
